@@ sv/mtvb_pkg.sv @@
// Shared types, widths and codes for the morph target vertex blend block.
`default_nettype none

package mtvb_pkg;

  // Field widths
  localparam int POS_W       = 32;
  localparam int WEIGHT_W    = 32;
  localparam int TOTAL_W     = 38;
  localparam int INDEX_W     = 6;
  localparam int COUNT_W     = 7;
  localparam int BASE_W      = 22;
  localparam int BASE_FRAC   = 16;

  // Blend arithmetic: factor magnitude, difference magnitude, product, sum
  localparam int MUL_W       = 31;
  localparam int MAG_W       = 33;
  localparam int PROD_W      = MUL_W + MAG_W;
  localparam int SUM_W       = PROD_W + 2;

  localparam int AXES        = 3;
  localparam int AXIS_W      = 2;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 22;

  // Parameter defaults
  localparam int DEF_MAX_SHAPES = 64;
  localparam int DEF_FRAC_BITS  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SHAPE_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_MORPH  = 2'd2;

  // Item opcodes and blend modes
  localparam logic OP_LOAD       = 1'b0;
  localparam logic OP_VERTEX     = 1'b1;
  localparam logic MODE_WEIGHTED = 1'b0;
  localparam logic MODE_INTERP   = 1'b1;

  // Axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Saturation limits
  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0]   POS_MAX   = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0]   POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

  // Source of the blend factor
  typedef enum logic [1:0] {
    MSEL_RAW,
    MSEL_ZERO,
    MSEL_FRAC
  } msel_t;

  // Controller to datapath
  typedef struct packed {
    logic              accept;
    logic              m_load;
    msel_t             m_sel;
    logic              div_start;
    logic              div_step;
    logic              diff;
    logic              mul_en;
    logic [AXIS_W-1:0] mul_axis;
    logic              add_en;
    logic [AXIS_W-1:0] add_axis;
    logic              out_load;
  } mtvb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_load;
    logic mode_interp;
    logic fold;
    logic w_neg;
    logic need_div;
    logic hit;
    logic do_blend;
    logic last_shape;
  } mtvb_sts_t;

endpackage

`default_nettype wire

@@ sv/mtvb_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none

module mtvb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/mtvb_ctrl.sv @@
// Sequencing state machine for the morph blend: read, divide, difference, multiply, add, result.
`default_nettype none

module mtvb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mtvb_pkg::mtvb_sts_t sts,
  output mtvb_pkg::mtvb_cmd_t cmd
);

  import mtvb_pkg::*;

  localparam int DIV_CNT_W = $clog2(MUL_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MUL_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_t;

  state_t              state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic [AXIS_W-1:0]    axis, axis_next;
  logic                 out_valid_next;

  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    cmd          = '0;
    state_next   = state;
    div_cnt_next = div_cnt;
    axis_next    = axis;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.in_load ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        // weight word is on the RAM output now
        if (sts.mode_interp) begin
          if (sts.hit) begin
            cmd.m_load = 1'b1;
            cmd.m_sel  = MSEL_FRAC;
            state_next = ST_DIFF;
          end else begin
            state_next = ST_FIN;
          end
        end else if (sts.fold) begin
          if (sts.w_neg) begin
            cmd.m_load = 1'b1;
            cmd.m_sel  = MSEL_ZERO;
            state_next = ST_DIFF;
          end else if (sts.need_div) begin
            cmd.div_start = 1'b1;
            div_cnt_next  = '0;
            state_next    = ST_DIV;
          end else begin
            cmd.m_load = 1'b1;
            cmd.m_sel  = MSEL_RAW;
            state_next = ST_DIFF;
          end
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ST_DIFF;
        end else begin
          div_cnt_next = div_cnt + DIV_CNT_W'(1);
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        axis_next  = AXIS_X;
        state_next = sts.do_blend ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        // multiply this axis while the previous one is summed
        cmd.mul_en   = 1'b1;
        cmd.mul_axis = axis;
        if (axis != AXIS_X) begin
          cmd.add_en   = 1'b1;
          cmd.add_axis = axis - AXIS_W'(1);
        end
        if (axis == AXIS_Z) begin
          state_next = ST_ADD;
        end else begin
          axis_next = axis + AXIS_W'(1);
        end
      end
      ST_ADD: begin
        cmd.add_en   = 1'b1;
        cmd.add_axis = AXIS_Z;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.last_shape) begin
          state_next = ST_IDLE;
        end else if (!(out_valid && out_stall)) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register valid: set on load, cleared when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      axis      <= AXIS_X;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/mtvb_datapath.sv @@
// Datapath: weight store, weight sum, divider, shared multiplier and accumulators.
`default_nettype none

module mtvb_datapath #(
  parameter int MAX_SHAPES = mtvb_pkg::DEF_MAX_SHAPES,
  parameter int FRAC_BITS  = mtvb_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [mtvb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mtvb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                opcode,
  input  logic [mtvb_pkg::INDEX_W-1:0]        shape_index,
  input  logic signed [mtvb_pkg::WEIGHT_W-1:0] weight,
  input  logic signed [mtvb_pkg::POS_W-1:0]   pos_x,
  input  logic signed [mtvb_pkg::POS_W-1:0]   pos_y,
  input  logic signed [mtvb_pkg::POS_W-1:0]   pos_z,
  input  logic                                last_shape,
  input  logic                                last_vertex,
  input  mtvb_pkg::mtvb_cmd_t                 cmd,
  output mtvb_pkg::mtvb_sts_t                 sts,
  output logic signed [mtvb_pkg::POS_W-1:0]   out_x,
  output logic signed [mtvb_pkg::POS_W-1:0]   out_y,
  output logic signed [mtvb_pkg::POS_W-1:0]   out_z,
  output logic                                object_done
);

  import mtvb_pkg::*;

  localparam int ADDR_W     = $clog2(MAX_SHAPES);
  localparam int CNT_W      = ($clog2(MAX_SHAPES + 1) > COUNT_W) ?
                              $clog2(MAX_SHAPES + 1) : COUNT_W;
  localparam int DIVIDEND_W = MUL_W + FRAC_BITS;
  localparam logic signed [TOTAL_W-1:0] ONE    = TOTAL_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0]   SAT_HI = SUM_W'(POS_MAX);
  localparam logic signed [SUM_W-1:0]   SAT_LO = SUM_W'(POS_MIN);

  // Configuration
  logic                blend_mode;
  logic [COUNT_W-1:0]  shape_count;
  logic [BASE_W-1:0]   base_morph;

  // Blend state
  logic signed [TOTAL_W-1:0] total;
  logic signed [POS_W-1:0]   acc [AXES];

  // Captured vertex item
  logic [INDEX_W-1:0]        s_r;
  logic signed [POS_W-1:0]   pos_r [AXES];
  logic                      last_shape_r;
  logic                      last_vertex_r;

  // Factor, divider and multiplier registers
  logic [MUL_W-1:0]          m;
  logic [TOTAL_W-1:0]        rem;
  logic [MUL_W-1:0]          dv;
  logic [MAG_W-1:0]          d_mag [AXES];
  logic                      d_neg [AXES];
  logic [PROD_W-1:0]         prod;
  logic                      prod_neg;

  logic [WEIGHT_W-1:0]       w_rd;
  logic                      wr_en;

  // Weight store
  assign wr_en = cmd.accept && (opcode == OP_LOAD) && (int'(shape_index) < MAX_SHAPES);

  mtvb_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_SHAPES)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(shape_index)),
    .wr_data (weight),
    .rd_en   (cmd.accept),
    .rd_addr (ADDR_W'(shape_index)),
    .rd_data (w_rd)
  );

  // Shape count clamp and interpolation pair
  logic [CNT_W-1:0] sc_ext, cnt, s_ext, i0_raw, i0, i1;
  logic             mode_interp, hit0, hit1, do_load;

  always_comb begin
    sc_ext = CNT_W'(shape_count);
    if (sc_ext == '0) begin
      cnt = CNT_W'(1);
    end else if (sc_ext > CNT_W'(MAX_SHAPES)) begin
      cnt = CNT_W'(MAX_SHAPES);
    end else begin
      cnt = sc_ext;
    end
    s_ext  = CNT_W'(s_r);
    i0_raw = CNT_W'(base_morph[BASE_W-1:BASE_FRAC]);
    i0     = (i0_raw >= cnt) ? cnt - CNT_W'(1) : i0_raw;
    i1     = ((i0 + CNT_W'(1)) < cnt) ? i0 + CNT_W'(1) : i0;
  end

  assign mode_interp = (blend_mode == MODE_INTERP);
  assign hit0        = (s_ext == i0);
  assign hit1        = (s_ext == i1);
  assign do_load     = mode_interp ? hit0 : (s_r == '0);

  always_comb begin
    sts.in_load     = (opcode == OP_LOAD);
    sts.mode_interp = mode_interp;
    sts.fold        = (s_ext < cnt);
    sts.w_neg       = w_rd[WEIGHT_W-1];
    sts.need_div    = (total > ONE);
    sts.hit         = hit0 || hit1;
    sts.do_blend    = mode_interp ? hit1 : 1'b1;
    sts.last_shape  = last_shape_r;
  end

  // Weight sum, saturating
  logic signed [TOTAL_W:0]   total_sum;
  logic signed [TOTAL_W-1:0] total_next;

  always_comb begin
    total_sum = (TOTAL_W + 1)'(total) + (TOTAL_W + 1)'(weight);
    if (shape_index == '0) begin
      total_next = TOTAL_W'(weight);
    end else if (total_sum[TOTAL_W] != total_sum[TOTAL_W-1]) begin
      total_next = total_sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_next = total_sum[TOTAL_W-1:0];
    end
  end

  // Restoring divider step: one quotient bit per cycle
  logic [DIVIDEND_W-1:0] dividend;
  logic [TOTAL_W:0]      trial, sub;
  logic                  ge;

  always_comb begin
    dividend = {w_rd[MUL_W-1:0], {FRAC_BITS{1'b0}}};
    trial    = {rem, dv[MUL_W-1]};
    sub      = trial - {1'b0, total};
    ge       = (trial >= {1'b0, total});
  end

  // Difference to the shape position, as sign and magnitude
  logic signed [MAG_W-1:0] d_val   [AXES];
  logic [MAG_W-1:0]        d_mag_c [AXES];

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      d_val[k]   = do_load ? '0 : (MAG_W'(pos_r[k]) - MAG_W'(acc[k]));
      d_mag_c[k] = d_val[k][MAG_W-1] ? MAG_W'(-d_val[k]) : MAG_W'(d_val[k]);
    end
  end

  // Scale, restore sign, add and saturate
  logic [PROD_W-1:0]       scaled;
  logic signed [SUM_W-1:0] term, sum;
  logic signed [POS_W-1:0] acc_new;

  always_comb begin
    scaled = mode_interp ? (prod >> BASE_FRAC) : (prod >> FRAC_BITS);
    term   = prod_neg ? -$signed(SUM_W'(scaled)) : $signed(SUM_W'(scaled));
    sum    = SUM_W'(acc[cmd.add_axis]) + term;
    if (sum > SAT_HI) begin
      acc_new = POS_MAX;
    end else if (sum < SAT_LO) begin
      acc_new = POS_MIN;
    end else begin
      acc_new = sum[POS_W-1:0];
    end
  end

  // Registers with a reset value: configuration, weight sum, accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode  <= MODE_WEIGHTED;
      shape_count <= COUNT_W'(1);
      base_morph  <= '0;
      total       <= '0;
      for (int k = 0; k < AXES; k++) begin
        acc[k] <= '0;
      end
    end else begin
      if (cfg_en) begin
        if (cfg_index == CFG_BLEND_MODE) begin
          blend_mode <= cfg_data[0];
        end
        if (cfg_index == CFG_SHAPE_COUNT) begin
          shape_count <= cfg_data[COUNT_W-1:0];
        end
        if (cfg_index == CFG_BASE_MORPH) begin
          base_morph <= cfg_data[BASE_W-1:0];
        end
      end
      if (cmd.accept && (opcode == OP_LOAD)) begin
        total <= total_next;
      end
      if (cmd.diff && do_load) begin
        for (int k = 0; k < AXES; k++) begin
          acc[k] <= pos_r[k];
        end
      end
      if (cmd.add_en) begin
        acc[cmd.add_axis] <= acc_new;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r           <= shape_index;
      pos_r[0]      <= pos_x;
      pos_r[1]      <= pos_y;
      pos_r[2]      <= pos_z;
      last_shape_r  <= last_shape;
      last_vertex_r <= last_vertex;
    end
    if (cmd.m_load) begin
      unique case (cmd.m_sel)
        MSEL_RAW:  m <= w_rd[MUL_W-1:0];
        MSEL_ZERO: m <= '0;
        MSEL_FRAC: m <= MUL_W'(base_morph[BASE_FRAC-1:0]);
        default:   m <= m;
      endcase
    end else if (cmd.div_start) begin
      // quotient fits the factor width, so the top dividend bits seed the remainder
      m   <= '0;
      rem <= TOTAL_W'(dividend[DIVIDEND_W-1:MUL_W]);
      dv  <= dividend[MUL_W-1:0];
    end else if (cmd.div_step) begin
      m   <= {m[MUL_W-2:0], ge};
      rem <= ge ? sub[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
      dv  <= dv << 1;
    end
    if (cmd.diff) begin
      for (int k = 0; k < AXES; k++) begin
        d_mag[k] <= d_mag_c[k];
        d_neg[k] <= d_val[k][MAG_W-1];
      end
    end
    if (cmd.mul_en) begin
      prod     <= PROD_W'(m) * PROD_W'(d_mag[cmd.mul_axis]);
      prod_neg <= d_neg[cmd.mul_axis];
    end
    if (cmd.out_load) begin
      out_x       <= acc[0];
      out_y       <= acc[1];
      out_z       <= acc[2];
      object_done <= last_vertex_r;
    end
  end

endmodule

`default_nettype wire

@@ sv/morph_target_vertex_blend_top.sv @@
// Top level of the morph target vertex blend block.
//
// Load items (opcode 0) leave the input ready: the weight goes into the shape's
// entry of the weight RAM and into the running weight sum. A vertex item
// (opcode 1) whose shape takes part in the blend goes through weight RAM read,
// difference, one shared 31x33 multiplier used by x, y and z in turn, accumulate
// and result before the block is ready again. A vertex item whose shape is not in
// use skips to the result step. In interpolate mode, an item for the lower shape
// of a distinct pair only loads the accumulators. In weighted mode, when the weight
// sum exceeds 1.0 and the shape's weight is not negative, the weight is normalised
// by a restoring divider giving one quotient bit per cycle. A vertex item marked
// last_shape yields one result item; it waits in the output register, and the
// next input item is taken while it does. A further result holds the block, with
// its input stalled, until the waiting one is taken.
// Configuration registers may be written only while the block is idle.
`default_nettype none

module morph_target_vertex_blend_top #(
  parameter int MAX_SHAPES = mtvb_pkg::DEF_MAX_SHAPES,
  parameter int FRAC_BITS  = mtvb_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_en,
  input  logic [mtvb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mtvb_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [mtvb_pkg::INDEX_W-1:0]         shape_index,
  input  logic signed [mtvb_pkg::WEIGHT_W-1:0] weight,
  input  logic signed [mtvb_pkg::POS_W-1:0]    pos_x,
  input  logic signed [mtvb_pkg::POS_W-1:0]    pos_y,
  input  logic signed [mtvb_pkg::POS_W-1:0]    pos_z,
  input  logic                                 last_shape,
  input  logic                                 last_vertex,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mtvb_pkg::POS_W-1:0]    out_x,
  output logic signed [mtvb_pkg::POS_W-1:0]    out_y,
  output logic signed [mtvb_pkg::POS_W-1:0]    out_z,
  output logic                                 object_done
);

  import mtvb_pkg::*;

  mtvb_cmd_t cmd;
  mtvb_sts_t sts;

  mtvb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtvb_datapath #(
    .MAX_SHAPES (MAX_SHAPES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .opcode      (opcode),
    .shape_index (shape_index),
    .weight      (weight),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .last_shape  (last_shape),
    .last_vertex (last_vertex),
    .cmd         (cmd),
    .sts         (sts),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .object_done (object_done)
  );

endmodule

`default_nettype wire

@@ sv/mtvb_checker.sv @@
// Port-level assertions for the morph blend top level, and the bind that attaches them.
`default_nettype none

module mtvb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        opcode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        object_done
);

  // A waiting result holds its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(object_done))
    else $error("result item changed while stalled");

  // A load item never raises a result
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == 1'b0) && !out_valid |=> !out_valid)
    else $error("load item produced a result");

  // A vertex item keeps the block busy for at least the next cycle
  a_vertex_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == 1'b1) |=> in_stall)
    else $error("vertex item did not occupy the block");

  // A new result only appears at the end of vertex work
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without vertex work");

endmodule

bind morph_target_vertex_blend_top mtvb_checker u_mtvb_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the morph target vertex blend block.
`default_nettype none

module tb;
  import mtvb_pkg::*;

  localparam int RANDOM_ITEMS  = 1500;
  localparam int SETTLE_CYCLES = 48;       // covers the slowest vertex item
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam longint UNIT      = longint'(1) << DEF_FRAC_BITS;

  typedef struct {
    logic                       op;
    logic [INDEX_W-1:0]         idx;
    logic signed [WEIGHT_W-1:0] wgt;
    logic signed [POS_W-1:0]    px, py, pz;
    logic                       ls, lv;
  } shape_item_t;

  typedef struct {
    logic signed [POS_W-1:0] x, y, z;
    logic                    done;
  } vertex_result_t;

  // Clock, reset and block inputs, all known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic opcode = 1'b0;
  logic [INDEX_W-1:0] shape_index = '0;
  logic signed [WEIGHT_W-1:0] weight = '0;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic last_shape = 1'b0, last_vertex = 1'b0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid, object_done;
  logic signed [POS_W-1:0] out_x, out_y, out_z;

  // Predicted block state
  logic                    cur_mode = MODE_WEIGHTED;
  logic [COUNT_W-1:0]      cur_count = COUNT_W'(1);
  logic [BASE_W-1:0]       cur_base = '0;
  longint                  shape_weight [DEF_MAX_SHAPES];
  longint                  weight_sum = 0;
  longint                  acc [AXES];
  vertex_result_t          pending_vertices [$];

  int          fails = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  morph_target_vertex_blend_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .shape_index(shape_index), .weight(weight),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .last_shape(last_shape), .last_vertex(last_vertex),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .object_done(object_done)
  );

  always #4 clk = ~clk;

  initial begin
    for (int i = 0; i < DEF_MAX_SHAPES; i++) shape_weight[i] = 0;
    for (int a = 0; a < AXES; a++) acc[a] = 0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 17);
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic int eff_of(logic [COUNT_W-1:0] c);
    if (c < 1) return 1;
    if (c > DEF_MAX_SHAPES) return DEF_MAX_SHAPES;
    return int'(c);
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > longint'(POS_MAX)) return longint'(POS_MAX);
    if (v < longint'(POS_MIN)) return longint'(POS_MIN);
    return v;
  endfunction

  // sign(d) * ((m * |d|) >> sh), product taken on magnitudes
  function automatic longint scaled_step(longint unsigned m, longint d, int sh);
    longint unsigned mag;
    longint unsigned prod;
    mag = (d < 0) ? -d : d;
    prod = (m * mag) >> sh;
    return (d < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic void fold_toward(longint unsigned m, int sh, longint p [AXES]);
    for (int a = 0; a < AXES; a++) acc[a] = clamp_pos(acc[a] + scaled_step(m, p[a] - acc[a], sh));
  endfunction

  // Update the predicted state for one accepted item; queue its result if any
  function automatic void predict_blend(shape_item_t it);
    longint p [AXES];
    longint wv;
    int cnt;
    int i0;
    int i1;
    longint unsigned frac;
    vertex_result_t r;
    cnt = eff_of(cur_count);
    if (it.op == OP_LOAD) begin
      shape_weight[it.idx] = it.wgt;
      weight_sum = (it.idx == 0) ? longint'(it.wgt) : weight_sum + it.wgt;
      if (weight_sum > longint'(TOTAL_MAX)) weight_sum = longint'(TOTAL_MAX);
      if (weight_sum < longint'(TOTAL_MIN)) weight_sum = longint'(TOTAL_MIN);
      return;
    end
    p[0] = it.px;
    p[1] = it.py;
    p[2] = it.pz;
    if (cur_mode == MODE_WEIGHTED) begin
      if (it.idx < cnt) begin
        wv = shape_weight[it.idx];
        if (it.idx == 0) acc = p;
        // negative weights drop out; a sum above one normalises
        if (wv < 0) wv = 0;
        else if (weight_sum > UNIT) wv = (wv * UNIT) / weight_sum;
        fold_toward(wv, DEF_FRAC_BITS, p);
      end
    end else begin
      i0 = int'(cur_base >> BASE_FRAC);
      if (i0 >= cnt) i0 = cnt - 1;
      i1 = (i0 + 1 < cnt) ? i0 + 1 : i0;
      frac = cur_base[BASE_FRAC-1:0];
      if (it.idx == i0) acc = p;
      if (it.idx == i1) fold_toward(frac, BASE_FRAC, p);
    end
    if (!it.ls) return;
    r.x = POS_W'(acc[0]);
    r.y = POS_W'(acc[1]);
    r.z = POS_W'(acc[2]);
    r.done = it.lv;
    pending_vertices.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [POS_W-1:0] want,
                                      logic [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fails++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    vertex_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_vertices.size() == 0) begin
        $error("result item with nothing expected");
        fails++;
      end else begin
        want = pending_vertices.pop_front();
        check_field("out_x", want.x, out_x);
        check_field("out_y", want.y, out_y);
        check_field("out_z", want.z, out_z);
        check_field("object_done", POS_W'(want.done), POS_W'(object_done));
      end
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic logic signed [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return -(32'sd1 + $urandom_range(0, 32'h1FFFF));
      3: return $urandom;
      4: return $urandom_range(32'h10000, 32'h80000);
      default: return $urandom_range(0, 32'h10000);
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return '0;
      3: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item from a falling edge, hold it until taken, predict it
  task automatic send_item(input shape_item_t it);
    if (!no_idle && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    opcode      <= it.op;
    shape_index <= it.idx;
    weight      <= it.wgt;
    pos_x       <= it.px;
    pos_y       <= it.py;
    pos_z       <= it.pz;
    last_shape  <= it.ls;
    last_vertex <= it.lv;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_blend(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(input int s, input logic signed [WEIGHT_W-1:0] w, input logic ls);
    shape_item_t it;
    it.op = OP_LOAD;
    it.idx = INDEX_W'(s);
    it.wgt = w;
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.ls = ls;
    it.lv = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_vertex(input int s, input logic signed [POS_W-1:0] x, y, z,
                             input logic ls, lv);
    shape_item_t it;
    it.op = OP_VERTEX;
    it.idx = INDEX_W'(s);
    it.wgt = $urandom;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.ls = ls;
    it.lv = lv;
    send_item(it);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_vertices.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    case (idx)
      CFG_BLEND_MODE:  cur_mode = val[0];
      CFG_SHAPE_COUNT: cur_count = val[COUNT_W-1:0];
      CFG_BASE_MORPH:  cur_base = val[BASE_W-1:0];
      default: ;
    endcase
  endtask

  // Registers change only once the block has gone quiet
  task automatic configure_blend(input logic m, input logic [COUNT_W-1:0] c,
                                 input logic [BASE_W-1:0] b);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_BLEND_MODE, CFG_DATA_W'(m));
    write_reg(CFG_SHAPE_COUNT, CFG_DATA_W'(c));
    write_reg(CFG_BASE_MORPH, CFG_DATA_W'(b));
    cfg_en <= 1'b0;
  endtask

  // One object: each shape's weight (interp mode: not always), vertices in order
  task automatic send_object(input int n_verts);
    int cnt;
    cnt = eff_of(cur_count);
    if (cur_mode == MODE_WEIGHTED || $urandom_range(0, 2) == 0) begin
      for (int s = 0; s < cnt; s++) send_load(s, rand_weight(), $urandom_range(0, 9) == 0);
    end
    for (int v = 0; v < n_verts; v++) begin
      for (int s = 0; s < cnt; s++) begin
        if (s != cnt - 1 && $urandom_range(0, 19) == 0) continue;
        send_vertex(s, rand_pos(), rand_pos(), rand_pos(), s == cnt - 1, v == n_verts - 1);
        // occasional stray items break the sequence
        case ($urandom_range(0, 39))
          0: send_vertex($urandom_range(0, 63), rand_pos(), rand_pos(), rand_pos(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          1: send_load($urandom_range(0, 63), rand_weight(), 1'b1);
          default: ;
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_weighted_basics();
    configure_blend(MODE_WEIGHTED, COUNT_W'(3), '0);
    // small weights, sum below one; a load marked last gives no result
    send_load(0, 32'sh4000, 1'b1);
    send_load(1, -32'sd1, 1'b0);
    send_load(2, 32'sh8000, 1'b0);
    send_vertex(0, POS_MAX, POS_MIN, 0, 1'b0, 1'b0);
    send_vertex(1, POS_MIN, POS_MAX, 32'sh1234, 1'b0, 1'b0);
    send_vertex(2, 0, 32'sh12345678, POS_MIN, 1'b1, 1'b0);
    // negative sum leaves a weight of four untouched: result saturates
    send_load(0, -32'sh50000, 1'b0);
    send_load(1, 0, 1'b0);
    send_load(2, 32'sh40000, 1'b0);
    send_vertex(0, POS_MAX, POS_MIN, POS_MAX, 1'b0, 1'b0);
    send_vertex(1, 0, 0, 0, 1'b0, 1'b0);
    send_vertex(2, POS_MIN, POS_MAX, POS_MIN, 1'b1, 1'b1);
    // sum above one: weights normalised; a missing shape, then a lone one
    send_load(0, POS_MAX, 1'b0);
    send_load(1, POS_MAX, 1'b0);
    send_load(2, 32'sh10000, 1'b0);
    send_vertex(0, 32'sh00050000, -32'sh00030000, 32'sh7FFF0000, 1'b0, 1'b0);
    send_vertex(2, -32'sh00020000, 32'sh00010000, POS_MIN, 1'b1, 1'b0);
    send_vertex(1, 32'sh01000000, POS_MAX, -32'sd1, 1'b1, 1'b1);
  endtask

  task automatic test_interp_basics();
    configure_blend(MODE_INTERP, COUNT_W'(4), 22'h018000);
    send_vertex(0, 32'sh10000, 32'sh20000, 32'sh30000, 1'b0, 1'b0);
    send_vertex(1, POS_MAX, POS_MIN, 0, 1'b0, 1'b0);
    send_vertex(2, POS_MIN, POS_MAX, 32'sh7000, 1'b1, 1'b0);
    send_vertex(3, 1, 1, 1, 1'b1, 1'b0);
    // position past the last shape clamps: both steps on one item
    configure_blend(MODE_INTERP, COUNT_W'(4), 22'h3FFFFF);
    send_vertex(3, POS_MAX, POS_MIN, -32'sd5, 1'b1, 1'b0);
    // zero fraction
    configure_blend(MODE_INTERP, COUNT_W'(4), 22'h020000);
    send_vertex(2, 32'sh00120000, -32'sh00340000, 32'sh56, 1'b0, 1'b0);
    send_vertex(3, POS_MIN, POS_MAX, 0, 1'b1, 1'b1);
  endtask

  // Drive the weight sum into both limits of its range
  task automatic test_weight_sum_limits();
    configure_blend(MODE_WEIGHTED, COUNT_W'(2), '0);
    send_load(0, POS_MAX, 1'b0);
    repeat (70) send_load($urandom_range(1, 63), POS_MAX, 1'b0);
    send_vertex(0, rand_pos(), rand_pos(), rand_pos(), 1'b0, 1'b0);
    send_vertex(1, rand_pos(), rand_pos(), rand_pos(), 1'b1, 1'b0);
    send_load(0, POS_MIN, 1'b0);
    repeat (70) send_load($urandom_range(1, 63), POS_MIN, 1'b0);
    send_vertex(0, rand_pos(), rand_pos(), rand_pos(), 1'b0, 1'b0);
    send_vertex(1, rand_pos(), rand_pos(), rand_pos(), 1'b1, 1'b1);
  endtask

  // Long receiver hold-off fills the block; then the sender pauses until drained
  task automatic test_backpressure();
    configure_blend(MODE_WEIGHTED, COUNT_W'(1), '0);
    send_load(0, 32'sh8000, 1'b0);
    hold_req++;
    for (int k = 0; k < 40; k++)
      send_vertex(0, rand_pos(), rand_pos(), rand_pos(), 1'b1, k == 39);
    wait_drained();
    for (int k = 0; k < 20; k++)
      send_vertex(0, rand_pos(), rand_pos(), rand_pos(), 1'b1, k == 19);
  endtask

  task automatic test_random_objects();
    int start;
    int done_items;
    logic m;
    logic [COUNT_W-1:0] c;
    logic [BASE_W-1:0] b;
    int cnt;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      done_items = items_sent - start;
      no_idle = (done_items > 600 && done_items < 1000);
      m = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0: c = '0;
        1: c = COUNT_W'(127);
        2: c = COUNT_W'(DEF_MAX_SHAPES);
        3, 4, 5: c = COUNT_W'($urandom_range(7, 16));
        default: c = COUNT_W'($urandom_range(1, 6));
      endcase
      cnt = eff_of(c);
      if ($urandom_range(0, 3) == 0) b = BASE_W'($urandom);
      else b = {6'($urandom_range(0, cnt - 1)), 16'($urandom)};
      configure_blend(m, c, b);
      repeat ($urandom_range(1, 3)) send_object(cnt > 8 ? 1 : $urandom_range(1, 4));
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_weighted_basics();
    test_interp_basics();
    test_weight_sum_limits();
    test_backpressure();
    test_random_objects();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && pending_vertices.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ morph_target_vertex_blend_top.f @@
sv/mtvb_pkg.sv
sv/mtvb_ram.sv
sv/mtvb_ctrl.sv
sv/mtvb_datapath.sv
sv/morph_target_vertex_blend_top.sv
sv/mtvb_checker.sv
test/tb.sv
